### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sorted set engine RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// check that an expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed");
// check that a condition implies a consequence at the next clock edge
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/core/sse_pkg.sv
// ----------------------------------------------------------------------------
// Sorted set engine package
// Sizes, command codes and item types shared by the engine modules.
// ----------------------------------------------------------------------------
package sse_pkg;

    localparam int CAPACITY  = 256;
    localparam int KEY_BITS  = 16;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int ENTRY_W   = 9;
    localparam int GROUP     = 16;
    localparam int NGROUPS   = (CAPACITY + GROUP - 1) / GROUP;

    localparam logic [1:0] CMD_MEMBER = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [CNT_W-1:0]    count_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] value;
    } in_item_t;

    typedef struct packed {
        logic               success;
        logic               full_res;
        logic [ENTRY_W-1:0] entry_count;
    } out_item_t;

    typedef struct packed {
        logic ins;
        logic del;
    } cell_ctrl_t;

endpackage

### rtl/core/sorted_set_engine_unit.sv
// ----------------------------------------------------------------------------
// Sorted set engine
// Keeps a set of distinct keys in ascending order in a chain of cells and
// answers member, insert and delete commands, one result per item.
//
//  channel | direction | ports                      | payload
//  s_      | in        | s_valid, s_ready, s_item   | command, value
//  m_      | out       | m_valid, m_ready, m_item   | success, full_res, entry_count
//
// An item steps through accept, compare in every cell, two levels of the
// match OR tree, then the shift step across the cell chain.
// Reset clears every cell valid bit and the count at once; no clearing pass.
// The result sits in an output register; the next item is accepted while it
// waits, and the shift step holds until that register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_set_engine_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sse_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output sse_pkg::out_item_t  m_item
);
    import sse_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CMP   = 5'b00010,
        ST_RED1  = 5'b00100,
        ST_RED2  = 5'b01000,
        ST_APPLY = 5'b10000
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] cmd_reg;
    key_t       key_reg;
    count_t     count_reg;
    count_t     count_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    out_item_t  m_item_reg;
    out_item_t  m_item_next;
    cell_ctrl_t ctrl;
    logic       found;
    logic       full;
    logic       apply_fire;
    logic       in_fire;

    sse_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .key     (key_reg),
        .ctrl    (ctrl),
        .found   (found)
    );

    assign s_ready    = (state_reg == ST_IDLE);
    assign in_fire    = s_valid && s_ready;
    assign full       = (count_reg == CNT_W'(CAPACITY));
    assign apply_fire = (state_reg == ST_APPLY) && (!m_valid_reg || m_ready);

    always_comb begin
        ctrl.ins    = apply_fire && (cmd_reg == CMD_INSERT) && !found && !full;
        ctrl.del    = apply_fire && (cmd_reg == CMD_DELETE) && found;
        count_next  = count_reg;
        if (ctrl.ins) begin
            count_next = count_reg + count_t'(1);
        end else if (ctrl.del) begin
            count_next = count_reg - count_t'(1);
        end
        m_item_next             = m_item_reg;
        m_valid_next            = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (apply_fire) begin
            m_valid_next            = 1'b1;
            m_item_next.success     = ((cmd_reg == CMD_MEMBER) && found) || ctrl.ins
                                      || ctrl.del;
            m_item_next.full_res    = (cmd_reg == CMD_INSERT) && !found && full;
            m_item_next.entry_count = ENTRY_W'(count_next);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_fire) state_next = ST_CMP;
            ST_CMP:   state_next = ST_RED1;
            ST_RED1:  state_next = ST_RED2;
            ST_RED2:  state_next = ST_APPLY;
            ST_APPLY: if (apply_fire) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            cmd_reg <= s_item.command;
            key_reg <= KEY_BITS'(s_item.value);
        end
        m_item_reg <= m_item_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(CAPACITY))
    `ASSERT_ALWAYS(a_ins_del_excl, aclk, aresetn, !(ctrl.ins && ctrl.del))
    `ASSERT_ALWAYS(a_full_no_success, aclk, aresetn, !(m_valid && m_item.full_res && m_item.success))
    `ASSERT_NEXT(a_ins_count, aclk, aresetn, ctrl.ins, count_reg == $past(count_reg) + count_t'(1))
    `ASSERT_NEXT(a_del_count, aclk, aresetn, ctrl.del, count_reg == $past(count_reg) - count_t'(1))

endmodule

### rtl/core/sse_cell.sv
// ----------------------------------------------------------------------------
// Sorted set cell
// Holds one key slot, compares it against the current key and shifts
// toward its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module sse_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  sse_pkg::key_t     key,
    input  sse_pkg::cell_ctrl_t ctrl,
    input  sse_pkg::key_t     left_val,
    input  logic              left_valid,
    input  logic              left_lt,
    input  sse_pkg::key_t     right_val,
    input  logic              right_valid,
    output sse_pkg::key_t     val,
    output logic              valid,
    output logic              lt,
    output logic              eq
);
    import sse_pkg::*;

    key_t val_reg;
    key_t val_next;
    logic valid_reg;
    logic valid_next;
    logic lt_reg;
    logic eq_reg;

    always_comb begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (ctrl.ins && !lt_reg) begin
            val_next   = left_lt ? key : left_val;
            valid_next = valid_reg | left_valid;
        end else if (ctrl.del && !lt_reg) begin
            val_next   = right_val;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            lt_reg    <= valid_reg && (val_reg < key);
            eq_reg    <= valid_reg && (val_reg == key);
        end
    end

    assign val   = val_reg;
    assign valid = valid_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

### rtl/core/sse_chain.sv
// ----------------------------------------------------------------------------
// Sorted set cell chain
// Row of key cells wired to their neighbors, with a two-level registered
// OR tree that reports a key match.
// ----------------------------------------------------------------------------
module sse_chain (
    input  logic                aclk,
    input  logic                aresetn,
    input  sse_pkg::key_t       key,
    input  sse_pkg::cell_ctrl_t ctrl,
    output logic                found
);
    import sse_pkg::*;

    key_t                        val_arr [CAPACITY];
    logic [CAPACITY-1:0]         valid_vec;
    logic [CAPACITY-1:0]         lt_vec;
    logic [CAPACITY-1:0]         eq_vec;
    logic [NGROUPS*GROUP-1:0]    eq_pad;
    logic [NGROUPS-1:0]          grp_or_reg;
    logic                        found_reg;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            key_t lval;
            logic lvalid;
            logic llt;
            key_t rval;
            logic rvalid;

            if (i == 0) begin : g_first
                assign lval   = key;
                assign lvalid = 1'b1;
                assign llt    = 1'b1;
            end else begin : g_mid
                assign lval   = val_arr[i-1];
                assign lvalid = valid_vec[i-1];
                assign llt    = lt_vec[i-1];
            end

            if (i == CAPACITY - 1) begin : g_last
                assign rval   = val_arr[i];
                assign rvalid = 1'b0;
            end else begin : g_inner
                assign rval   = val_arr[i+1];
                assign rvalid = valid_vec[i+1];
            end

            sse_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .key         (key),
                .ctrl        (ctrl),
                .left_val    (lval),
                .left_valid  (lvalid),
                .left_lt     (llt),
                .right_val   (rval),
                .right_valid (rvalid),
                .val         (val_arr[i]),
                .valid       (valid_vec[i]),
                .lt          (lt_vec[i]),
                .eq          (eq_vec[i])
            );
        end
    endgenerate

    always_comb begin
        eq_pad                 = '0;
        eq_pad[CAPACITY-1:0]   = eq_vec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_or_reg <= '0;
        end else begin
            for (int g = 0; g < NGROUPS; g++) begin
                grp_or_reg[g] <= |eq_pad[g*GROUP +: GROUP];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= |grp_or_reg;
        end
    end

    assign found = found_reg;

endmodule

### tb/sorted_set_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// Sorted set engine testbench
// Drives member, insert, delete and unused commands through the valid/ready
// input channel and checks every result against a membership model of the
// set: success, full refusal and key count after each item. The run walks
// the set from empty to full capacity and back, with random idling on both
// channels, a long receiver hold-off and a final stretch at full rate.
// ----------------------------------------------------------------------------
module sorted_set_engine_unit_tb;
    import sse_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         STALL_LIMIT = 2000;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_item;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_item;

    bit         key_held [0:65535];
    key_t       held_keys [$];
    int         held_total;
    out_item_t  pending_results [$];

    bit         idle_en;
    int         hold_off_len;
    int         error_count;
    int         cmd_seen [4];
    int         full_refusals;
    int         peak_held;

    sorted_set_engine_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #6 aclk = ~aclk;

    function automatic out_item_t set_model_apply(in_item_t it);
        out_item_t res;
        bit        found;
        found = key_held[it.value];
        res = '0;
        cmd_seen[it.command]++;
        case (it.command)
            CMD_MEMBER: begin
                res.success = found;
            end
            CMD_INSERT: begin
                if (!found) begin
                    if (held_total >= CAPACITY) begin
                        res.full_res = 1'b1;
                        full_refusals++;
                    end else begin
                        key_held[it.value] = 1'b1;
                        held_keys.push_back(it.value);
                        held_total++;
                        res.success = 1'b1;
                    end
                end
            end
            CMD_DELETE: begin
                if (found) begin
                    key_held[it.value] = 1'b0;
                    foreach (held_keys[i]) begin
                        if (held_keys[i] == it.value) begin
                            held_keys.delete(i);
                            break;
                        end
                    end
                    held_total--;
                    res.success = 1'b1;
                end
            end
            default: ;
        endcase
        if (held_total > peak_held) peak_held = held_total;
        res.entry_count = held_total[ENTRY_W-1:0];
        return res;
    endfunction

    function automatic key_t pick_held_key();
        if (held_keys.size() == 0) return key_t'($urandom_range(0, 65535));
        return held_keys[$urandom_range(0, held_keys.size() - 1)];
    endfunction

    function automatic key_t pick_absent_key();
        key_t k;
        do k = key_t'($urandom_range(0, 65535)); while (key_held[k]);
        return k;
    endfunction

    function automatic key_t pick_pool_key();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return 16'hFFFF;
        if (r == 1) return key_t'($urandom_range(0, 65535));
        return key_t'($urandom_range(0, 39) * 1680);
    endfunction

    task automatic send_item(input logic [1:0] cmd, input key_t value);
        int       gap;
        in_item_t it;
        it.command = cmd;
        it.value   = value;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(set_model_apply(it));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic send_random_mix(input int count);
        int r;
        repeat (count) begin
            r = $urandom_range(0, 19);
            if (r < 8)       send_item(CMD_INSERT, pick_pool_key());
            else if (r < 14) send_item(CMD_DELETE, pick_pool_key());
            else if (r < 19) send_item(CMD_MEMBER, pick_pool_key());
            else             send_item(CMD_UNUSED, pick_pool_key());
        end
    endtask

    task automatic test_directed();
        send_item(CMD_MEMBER, 16'h0000);
        send_item(CMD_DELETE, 16'h0000);
        send_item(CMD_INSERT, 16'h0000);
        send_item(CMD_INSERT, 16'hFFFF);
        send_item(CMD_INSERT, 16'h0000);
        send_item(CMD_MEMBER, 16'h0000);
        send_item(CMD_MEMBER, 16'hFFFF);
        send_item(CMD_MEMBER, 16'h0001);
        send_item(CMD_INSERT, 16'h8000);
        send_item(CMD_INSERT, 16'h0001);
        send_item(CMD_UNUSED, 16'hFFFF);
        send_item(CMD_UNUSED, 16'h0000);
        send_item(CMD_DELETE, 16'h8000);
        send_item(CMD_DELETE, 16'h8000);
        send_item(CMD_MEMBER, 16'h8000);
        send_item(CMD_INSERT, 16'h5555);
        send_item(CMD_INSERT, 16'hAAAA);
        send_item(CMD_MEMBER, 16'hAAAA);
        send_item(CMD_DELETE, 16'hFFFF);
        send_item(CMD_DELETE, 16'h0000);
        send_item(CMD_DELETE, 16'h0001);
        send_item(CMD_MEMBER, 16'h0001);
        wait_drained();
    endtask

    task automatic test_random_mix();
        send_random_mix(200);
    endtask

    task automatic test_fill_and_overflow();
        int r;
        while (held_total < CAPACITY) begin
            if ($urandom_range(0, 9) < 9) send_item(CMD_INSERT, pick_absent_key());
            else                          send_item(CMD_INSERT, pick_held_key());
        end
        repeat (30) begin
            r = $urandom_range(0, 9);
            if (r < 4)      send_item(CMD_INSERT, pick_absent_key());
            else if (r < 7) send_item(CMD_INSERT, pick_held_key());
            else if (r < 9) send_item(CMD_MEMBER, pick_held_key());
            else            send_item(CMD_UNUSED, pick_absent_key());
        end
    endtask

    task automatic test_output_backpressure();
        int r;
        hold_off_len = 80;
        repeat (40) begin
            r = $urandom_range(0, 2);
            if (r == 0)      send_item(CMD_DELETE, pick_held_key());
            else if (r == 1) send_item(CMD_INSERT, pick_absent_key());
            else             send_item(CMD_MEMBER, pick_held_key());
        end
        wait_drained();
    endtask

    task automatic test_drain_to_empty();
        int r;
        while (held_total > 0) begin
            r = $urandom_range(0, 9);
            if (r < 8)       send_item(CMD_DELETE, pick_held_key());
            else if (r == 8) send_item(CMD_DELETE, pick_absent_key());
            else             send_item(CMD_MEMBER, pick_held_key());
        end
        send_item(CMD_DELETE, pick_absent_key());
        send_item(CMD_MEMBER, 16'hFFFF);
    endtask

    task automatic test_full_rate();
        idle_en = 1'b0;
        send_random_mix(100);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off_len > 0) begin
            m_ready <= 1'b0;
            hold_off_len = hold_off_len - 1;
        end else if (idle_en && !m_ready && m_valid === 1'bx) begin
            m_ready <= 1'b1;
        end else if (idle_en && m_ready && $urandom_range(0, 4) == 0) begin
            m_ready <= 1'b0;
            hold_off_len = $urandom_range(0, 6);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, m_item);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_item.success !== want.success) begin
                    $display("%0t: success mismatch, expected %0b, actual %0b",
                             $time, want.success, m_item.success);
                    error_count++;
                end
                if (m_item.full_res !== want.full_res) begin
                    $display("%0t: full_res mismatch, expected %0b, actual %0b",
                             $time, want.full_res, m_item.full_res);
                    error_count++;
                end
                if (m_item.entry_count !== want.entry_count) begin
                    $display("%0t: entry_count mismatch, expected %0d, actual %0d",
                             $time, want.entry_count, m_item.entry_count);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, pending_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_item       = '0;
        m_ready      = 1'b0;
        idle_en      = 1'b1;
        hold_off_len = 0;
        error_count  = 0;
        held_total   = 0;
        full_refusals = 0;
        peak_held    = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_mix();
        test_fill_and_overflow();
        test_output_backpressure();
        test_drain_to_empty();
        test_full_rate();

        wait_drained();
        repeat (12) @(posedge aclk);

        $display("items: %0d member, %0d insert, %0d delete, %0d unused command",
                 cmd_seen[CMD_MEMBER], cmd_seen[CMD_INSERT], cmd_seen[CMD_DELETE],
                 cmd_seen[CMD_UNUSED]);
        $display("set filled to %0d keys, %0d inserts refused as full, %0d mismatches",
                 peak_held, full_refusals, error_count);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/sse_pkg.sv
rtl/core/sse_cell.sv
rtl/core/sse_chain.sv
rtl/core/sorted_set_engine_unit.sv
tb/sorted_set_engine_unit_tb.sv
